@@ hw/rtl/fvn2d_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fvn2d_pkg: shared types and constants
// Configuration layout, queue entry and hash constants of the fractal
// value noise block.
// ----------------------------------------------------------------------------
package fvn2d_pkg;

  // Configuration register indexes
  localparam logic [7:0] REG_PERSISTENCE = 8'd0;
  localparam logic [7:0] REG_BASE_FREQ   = 8'd1;
  localparam logic [7:0] REG_OCT_COUNT   = 8'd2;
  localparam logic [7:0] REG_SEED        = 8'd3;

  // Hash constants
  localparam logic [31:0] HASH_YMUL = 32'd3251;
  localparam logic [31:0] HASH_M1   = 32'd15731;
  localparam logic [31:0] HASH_A1   = 32'd789221;
  localparam logic [31:0] HASH_A2   = 32'd1376312589;
  localparam logic [31:0] NOISE_ONE = 32'h4000_0000;

  // Amplitude of the first octave, Q.16
  localparam logic [16:0] AMP_ONE = 17'h1_0000;

  // Coordinate queue
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  // Width of coordinate times base frequency
  localparam int PW = 56;

  typedef struct packed {
    logic [15:0] persistence;
    logic [23:0] base_freq;
    logic [3:0]  octave_count;
    logic [31:0] seed;
  } cfg_t;

  typedef struct packed {
    logic signed [PW-1:0] px;
    logic signed [PW-1:0] py;
  } q_entry_t;

endpackage

@@ hw/rtl/fractal_value_noise_2d_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fractal_value_noise_2d_top: fractal 2D value noise
// Configuration registers, input stage, coordinate queue and octave engine.
// ----------------------------------------------------------------------------
// Each coordinate item runs as many octaves as the octave count gives (one
// octave when the count is zero, at most MAX_OCTAVES): the octave engine
// issues one octave per cycle while out_stall does not hold a result, into
// a hash, smooth and blend pipeline, and the next item's octaves follow
// without a gap. A 4-entry queue lets new items be taken while a result
// waits on out_stall; a held result freezes the octave pipeline until it
// is taken. Configuration is written through cfg_valid/cfg_index/cfg_data,
// cfg_ready is always high.
module fractal_value_noise_2d_top #(
  parameter int MAX_OCTAVES = 8,
  parameter int FRAC_BITS   = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_coord_x,
  input  logic signed [31:0] in_coord_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [23:0] out_noise_value,
  output logic               out_saturated,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  fvn2d_pkg::cfg_t     cfg_r;
  fvn2d_pkg::q_entry_t push_data, head;
  logic                push, pop, q_full, q_empty;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.persistence  <= 16'd32768;
      cfg_r.base_freq    <= 24'd65536;
      cfg_r.octave_count <= 4'd4;
      cfg_r.seed         <= 32'd2;
    end else if (cfg_valid) begin
      case (cfg_index)
        fvn2d_pkg::REG_PERSISTENCE: cfg_r.persistence  <= cfg_data[15:0];
        fvn2d_pkg::REG_BASE_FREQ:   cfg_r.base_freq    <= cfg_data[23:0];
        fvn2d_pkg::REG_OCT_COUNT:   cfg_r.octave_count <= cfg_data[3:0];
        fvn2d_pkg::REG_SEED:        cfg_r.seed         <= cfg_data;
        default: ;
      endcase
    end
  end

  fvn2d_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_coord_x (in_coord_x),
    .in_coord_y (in_coord_y),
    .base_freq  (cfg_r.base_freq),
    .push       (push),
    .push_data  (push_data),
    .q_full     (q_full)
  );

  fvn2d_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .full      (q_full),
    .empty     (q_empty)
  );

  fvn2d_back #(
    .MAX_OCTAVES (MAX_OCTAVES),
    .FRAC_BITS   (FRAC_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .head            (head),
    .empty           (q_empty),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_noise_value (out_noise_value),
    .out_saturated   (out_saturated)
  );

endmodule

@@ hw/rtl/fvn2d_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fvn2d_front: input stage
// Accepts a coordinate item and scales it by the base frequency.
// ----------------------------------------------------------------------------
module fvn2d_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [31:0]  in_coord_x,
  input  logic signed [31:0]  in_coord_y,
  input  logic [23:0]         base_freq,
  output logic                push,
  output fvn2d_pkg::q_entry_t push_data,
  input  logic                q_full
);

  logic                            fr_v_r, fr_v_nxt;
  logic signed [fvn2d_pkg::PW-1:0] px_r, py_r;
  logic                            accept;

  // stall only while the holding register cannot drain
  assign in_stall = fr_v_r & q_full;
  assign accept   = in_valid & ~in_stall;
  assign push     = fr_v_r & ~q_full;

  assign push_data.px = px_r;
  assign push_data.py = py_r;

  always_comb begin
    fr_v_nxt = fr_v_r;
    if (accept) begin
      fr_v_nxt = 1'b1;
    end else if (push) begin
      fr_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_v_r <= 1'b0;
    end else begin
      fr_v_r <= fr_v_nxt;
    end
  end

  // coordinate times frequency, signed Q16.16 x unsigned Q8.16
  always_ff @(posedge clk) begin
    if (accept) begin
      px_r <= fvn2d_pkg::PW'(in_coord_x * $signed({1'b0, base_freq}));
      py_r <= fvn2d_pkg::PW'(in_coord_y * $signed({1'b0, base_freq}));
    end
  end

endmodule

@@ hw/rtl/fvn2d_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fvn2d_queue: coordinate queue
// Short FIFO between the input stage and the octave engine.
// ----------------------------------------------------------------------------
module fvn2d_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  fvn2d_pkg::q_entry_t push_data,
  input  logic                pop,
  output fvn2d_pkg::q_entry_t head,
  output logic                full,
  output logic                empty
);

  fvn2d_pkg::q_entry_t          mem_r [fvn2d_pkg::QDEPTH];
  logic [fvn2d_pkg::QAW-1:0]    wp_r, wp_nxt, rp_r, rp_nxt;
  logic [fvn2d_pkg::QAW:0]      cnt_r, cnt_nxt;

  assign full  = (cnt_r == (fvn2d_pkg::QAW+1)'(fvn2d_pkg::QDEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rp_r];

  // pointer and fill count
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = wp_r + 1'b1;
    end
    if (pop) begin
      rp_nxt = rp_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

endmodule

@@ hw/rtl/fvn2d_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fvn2d_back: octave engine
// Issues one octave per cycle while not stalled into a hash, smooth and blend
// pipeline and accumulates the weighted octaves into the saturated result.
// ----------------------------------------------------------------------------
module fvn2d_back #(
  parameter int MAX_OCTAVES = 8,
  parameter int FRAC_BITS   = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  fvn2d_pkg::cfg_t     cfg,
  input  fvn2d_pkg::q_entry_t head,
  input  logic                empty,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [23:0]  out_noise_value,
  output logic                out_saturated
);

  localparam int FB = FRAC_BITS;
  localparam int KW = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;
  localparam int CW = 36;
  localparam int WW = FB + 2;
  localparam int DW = CW + WW + 2;
  localparam int VW = CW + 18;
  localparam int PW = fvn2d_pkg::PW;

  logic adv;

  // ---------------- sequencer ----------------
  logic                 seq_v_r;
  logic signed [PW-1:0] seq_px_r, seq_py_r;
  logic [KW-1:0]        k_r;
  logic [KW:0]          cnt_r, cnt_eff;
  logic [16:0]          amp_r;
  logic [32:0]          amp_prod;
  logic                 issue, last_issue;
  logic [63:0]          sh_x, sh_y;
  logic [31:0]          bx_c, by_c;

  assign adv        = ~(out_valid & out_stall);
  assign issue      = seq_v_r & adv;
  assign last_issue = ({1'b0, k_r} == (cnt_r - 1'b1));
  assign pop        = ~empty & (~seq_v_r | (issue & last_issue));
  assign amp_prod   = amp_r * cfg.persistence;

  // octaves to run; zero count runs one octave at zero amplitude
  always_comb begin
    if (cfg.octave_count == 4'd0) begin
      cnt_eff = (KW+1)'(1);
    end else if ({28'd0, cfg.octave_count} > MAX_OCTAVES) begin
      cnt_eff = (KW+1)'(MAX_OCTAVES);
    end else begin
      cnt_eff = (KW+1)'(cfg.octave_count);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_v_r <= 1'b0;
    end else if (pop) begin
      seq_v_r <= 1'b1;
    end else if (issue && last_issue) begin
      seq_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      seq_px_r <= head.px;
      seq_py_r <= head.py;
      k_r      <= '0;
      cnt_r    <= cnt_eff;
      amp_r    <= (cfg.octave_count == 4'd0) ? 17'd0 : fvn2d_pkg::AMP_ONE;
    end else if (issue) begin
      k_r   <= k_r + 1'b1;
      amp_r <= amp_prod[32:16];
    end
  end

  // scale by 2^k and split into lattice index and fraction
  assign sh_x = {{(64-PW){seq_px_r[PW-1]}}, seq_px_r} << k_r;
  assign sh_y = {{(64-PW){seq_py_r[PW-1]}}, seq_py_r} << k_r;
  assign bx_c = sh_x[63:32] + cfg.seed;
  assign by_c = sh_y[63:32] + cfg.seed;

  // ---------------- pipeline valid and side band ----------------
  logic        v_r    [1:11];
  logic        last_r [1:11];
  logic [16:0] amp_p  [1:11];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 1; s <= 11; s++) begin
        v_r[s] <= 1'b0;
      end
    end else if (adv) begin
      v_r[1] <= seq_v_r;
      for (int s = 2; s <= 11; s++) begin
        v_r[s] <= v_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      last_r[1] <= last_issue;
      amp_p[1]  <= amp_r;
      for (int s = 2; s <= 11; s++) begin
        last_r[s] <= last_r[s-1];
        amp_p[s]  <= amp_p[s-1];
      end
    end
  end

  // ---------------- stage 1: lattice origin ----------------
  logic [31:0]   s1_bx, s1_by;
  logic [FB-1:0] s1_fx, s1_fy;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_bx <= bx_c;
      s1_by <= by_c;
      s1_fx <= sh_x[31 -: FB];
      s1_fy <= sh_y[31 -: FB];
    end
  end

  // ---------------- stage 2: lattice rows and columns ----------------
  logic [31:0]   s2_x  [4];
  logic [31:0]   s2_ym [4];
  logic [FB-1:0] s2_fx, s2_fy, s2_sx, s2_sy;
  logic [2*FB-1:0] sq_x, sq_y;

  assign sq_x = s1_fx * s1_fx;
  assign sq_y = s1_fy * s1_fy;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        s2_x[i]  <= s1_bx + 32'(i) - 32'd1;
        s2_ym[i] <= (s1_by + 32'(i) - 32'd1) * fvn2d_pkg::HASH_YMUL;
      end
      s2_fx <= s1_fx;
      s2_fy <= s1_fy;
      s2_sx <= sq_x[2*FB-1:FB];
      s2_sy <= sq_y[2*FB-1:FB];
    end
  end

  // ---------------- stage 3: hash mix and square ----------------
  logic [31:0]     s3_n  [16];
  logic [31:0]     s3_nn [16];
  logic [WW-1:0]   s3_wx, s3_wy;
  logic [31:0]     mix   [16];
  logic [WW-1:0]   tx, ty;
  logic [2*FB+1:0] wpx, wpy;

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      for (int i = 0; i < 4; i++) begin
        mix[4*j+i] = s2_x[i] + s2_ym[j];
        mix[4*j+i] = (mix[4*j+i] << 13) ^ mix[4*j+i];
      end
    end
  end

  // smoothstep weight
  assign tx  = (WW'(3) << FB) - {1'b0, s2_fx, 1'b0};
  assign ty  = (WW'(3) << FB) - {1'b0, s2_fy, 1'b0};
  assign wpx = s2_sx * tx;
  assign wpy = s2_sy * ty;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int e = 0; e < 16; e++) begin
        s3_n[e]  <= mix[e];
        s3_nn[e] <= mix[e] * mix[e];
      end
      s3_wx <= wpx[2*FB+1:FB];
      s3_wy <= wpy[2*FB+1:FB];
    end
  end

  // ---------------- stage 4: polynomial ----------------
  logic [31:0]   s4_n [16];
  logic [31:0]   s4_q [16];
  logic [WW-1:0] s4_wx, s4_wy;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int e = 0; e < 16; e++) begin
        s4_n[e] <= s3_n[e];
        s4_q[e] <= s3_nn[e] * fvn2d_pkg::HASH_M1 + fvn2d_pkg::HASH_A1;
      end
      s4_wx <= s3_wx;
      s4_wy <= s3_wy;
    end
  end

  // ---------------- stage 5: lattice noise ----------------
  logic signed [31:0] s5_g [16];
  logic [WW-1:0]      s5_wx, s5_wy;
  logic [31:0]        hv   [16];

  always_comb begin
    for (int e = 0; e < 16; e++) begin
      hv[e] = s4_n[e] * s4_q[e] + fvn2d_pkg::HASH_A2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int e = 0; e < 16; e++) begin
        s5_g[e] <= $signed(fvn2d_pkg::NOISE_ONE - {1'b0, hv[e][30:0]});
      end
      s5_wx <= s4_wx;
      s5_wy <= s4_wy;
    end
  end

  // ---------------- stage 6: smoothed corners ----------------
  logic signed [CW-1:0] s6_c [4];
  logic [WW-1:0]        s6_wx, s6_wy;
  logic signed [CW-1:0] cs   [4];

  function automatic logic signed [CW-1:0] gx(input logic signed [31:0] v);
    gx = CW'(v);
  endfunction

  always_comb begin
    for (int cy = 1; cy <= 2; cy++) begin
      for (int cx = 1; cx <= 2; cx++) begin
        cs[2*(cy-1)+(cx-1)] =
            gx(s5_g[4*(cy-1)+cx-1]) + gx(s5_g[4*(cy-1)+cx+1])
          + gx(s5_g[4*(cy+1)+cx-1]) + gx(s5_g[4*(cy+1)+cx+1])
          + ((gx(s5_g[4*cy+cx-1]) + gx(s5_g[4*cy+cx+1])
            + gx(s5_g[4*(cy-1)+cx]) + gx(s5_g[4*(cy+1)+cx])) <<< 1)
          + (gx(s5_g[4*cy+cx]) <<< 2);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 4; c++) begin
        s6_c[c] <= cs[c];
      end
      s6_wx <= s5_wx;
      s6_wy <= s5_wy;
    end
  end

  // ---------------- stage 7: x blend products ----------------
  // corner order: 0 = c00, 1 = c10, 2 = c01, 3 = c11
  logic signed [DW-1:0] s7_p0, s7_p1;
  logic signed [CW-1:0] s7_c00, s7_c01;
  logic [WW-1:0]        s7_wy;

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_p0  <= DW'((CW+1)'(s6_c[1]) - (CW+1)'(s6_c[0])) * $signed({1'b0, s6_wx});
      s7_p1  <= DW'((CW+1)'(s6_c[3]) - (CW+1)'(s6_c[2])) * $signed({1'b0, s6_wx});
      s7_c00 <= s6_c[0];
      s7_c01 <= s6_c[2];
      s7_wy  <= s6_wy;
    end
  end

  // ---------------- stage 8: x blend ----------------
  logic signed [CW-1:0] s8_e0, s8_e1;
  logic [WW-1:0]        s8_wy;
  logic signed [DW-1:0] sh_p0, sh_p1;

  assign sh_p0 = s7_p0 >>> FB;
  assign sh_p1 = s7_p1 >>> FB;

  always_ff @(posedge clk) begin
    if (adv) begin
      s8_e0 <= s7_c00 + sh_p0[CW-1:0];
      s8_e1 <= s7_c01 + sh_p1[CW-1:0];
      s8_wy <= s7_wy;
    end
  end

  // ---------------- stage 9: y blend product ----------------
  logic signed [DW-1:0] s9_p;
  logic signed [CW-1:0] s9_e0;

  always_ff @(posedge clk) begin
    if (adv) begin
      s9_p  <= DW'((CW+1)'(s8_e1) - (CW+1)'(s8_e0)) * $signed({1'b0, s8_wy});
      s9_e0 <= s8_e0;
    end
  end

  // ---------------- stage 10: octave value ----------------
  logic signed [CW-1:0] s10_v;
  logic signed [DW-1:0] sh_p;

  assign sh_p = s9_p >>> FB;

  always_ff @(posedge clk) begin
    if (adv) begin
      s10_v <= s9_e0 + sh_p[CW-1:0];
    end
  end

  // ---------------- stage 11: amplitude ----------------
  logic signed [VW-1:0] s11_va;

  always_ff @(posedge clk) begin
    if (adv) begin
      s11_va <= VW'(s10_v * $signed({1'b0, amp_p[10]}));
    end
  end

  // ---------------- accumulate and saturate ----------------
  logic signed [63:0] acc_r, total, res;
  logic               out_v_r;
  logic signed [23:0] noise_r;
  logic               sat_r;
  logic               hi, lo;

  assign total = acc_r + 64'(s11_va);
  assign res   = total >>> 30;
  assign hi    = (res > 64'sd8388607);
  assign lo    = (res < -64'sd8388608);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= v_r[11] & last_r[11];
      if (v_r[11]) begin
        acc_r <= last_r[11] ? 64'sd0 : total;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v_r[11] && last_r[11]) begin
      noise_r <= hi ? 24'sh7fffff : (lo ? 24'sh800000 : res[23:0]);
      sat_r   <= hi | lo;
    end
  end

  assign out_valid       = out_v_r;
  assign out_noise_value = noise_r;
  assign out_saturated   = sat_r;

endmodule
